### design/ucfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART command frame parser package
// Shared types and constants for the frame parser block.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h2f;
  localparam int         CAP_DEPTH     = 5;
  localparam logic [2:0] POS_HUNT      = 3'd0;
  localparam logic [2:0] POS_FIRST     = 3'd1;
  localparam logic [2:0] POS_LAST_CAP  = 3'd5;
  localparam logic [2:0] POS_CHECKSUM  = 3'd7;

  // configuration register indexes
  localparam logic REG_WRITE_CMD = 1'b0;
  localparam logic REG_READ_CMD  = 1'b1;

  // result kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef struct packed {
    logic [7:0] write_cmd;
    logic [7:0] read_cmd;
  } cfg_t;

  typedef struct packed {
    logic [15:0] warning_count;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic        event_kind;
    logic [15:0] reply_word;
    logic [7:0]  record_checksum;
    logic [15:0] offset_word;
    logic [15:0] slope_word;
  } result_t;

endpackage

### design/ucfp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the write and read command codes.
// ----------------------------------------------------------------------------
module ucfp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ucfp_pkg::cfg_t cfg
);
  import ucfp_pkg::*;

  logic [7:0] write_cmd_r;
  logic [7:0] read_cmd_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_cmd_r <= 8'd1;
      read_cmd_r  <= 8'd2;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WRITE_CMD: write_cmd_r <= pwdata[7:0];
        REG_READ_CMD:  read_cmd_r  <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WRITE_CMD: prdata = {24'd0, write_cmd_r};
      REG_READ_CMD:  prdata = {24'd0, read_cmd_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.write_cmd = write_cmd_r;
  assign cfg.read_cmd  = read_cmd_r;

endmodule

### design/ucfp_frame_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame core
// Input register, frame position tracking, checksum and result decode.
// ----------------------------------------------------------------------------
module ucfp_frame_core (
  input  logic               clk,
  input  logic               rst_n,
  input  ucfp_pkg::cfg_t     cfg,
  input  logic               req_valid,
  output logic               req_ready,
  input  ucfp_pkg::req_t     req,
  output logic               res_valid,
  input  logic               res_ready,
  output ucfp_pkg::result_t  res
);
  import ucfp_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  req_t       s1_req_r;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] cap_r [CAP_DEPTH];
  logic [2:0] cap_idx;
  logic       take;
  logic       sum_ok;
  logic       is_write;
  logic       is_read;
  logic [7:0] b;

  assign b         = s1_req_r.rx_byte;
  assign take      = s1_valid_r & res_ready;
  assign req_ready = ~s1_valid_r | res_ready;
  assign cap_idx   = pos_r - 3'd1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (req_ready) begin
      s1_valid_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req_r <= req;
    end
  end

  // frame position and running sum
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (take) begin
      priority if (pos_r == POS_HUNT) begin
        if (b == SYNC_BYTE) begin
          pos_nxt = POS_FIRST;
          sum_nxt = 8'd0;
        end
      end else if (pos_r < POS_CHECKSUM) begin
        sum_nxt = sum_r + b;
        pos_nxt = pos_r + 3'd1;
      end else begin
        pos_nxt = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // keep the command byte and the four parameter bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      if (take && pos_r != POS_HUNT && pos_r <= POS_LAST_CAP && cap_idx == 3'(i)) begin
        cap_r[i] <= b;
      end
    end
  end

  assign sum_ok   = (pos_r == POS_CHECKSUM) && (b == sum_r);
  assign is_write = cap_r[0] == cfg.write_cmd;
  assign is_read  = cap_r[0] == cfg.read_cmd;

  assign res_valid = s1_valid_r & sum_ok & (is_write | is_read);

  always_comb begin
    res = '0;
    if (is_write) begin
      res.event_kind      = KIND_STORE;
      res.slope_word      = {cap_r[1], cap_r[2]};
      res.offset_word     = {cap_r[3], cap_r[4]};
      res.record_checksum = cap_r[1] + cap_r[2] + cap_r[3] + cap_r[4];
    end else begin
      res.event_kind = KIND_REPLY;
      res.reply_word = s1_req_r.warning_count;
    end
  end

endmodule

### design/ucfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ucfp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  ucfp_pkg::result_t  res,
  output logic               out_valid,
  input  logic               out_ready,
  output ucfp_pkg::result_t  out_res
);
  import ucfp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_ready = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### design/uart_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART command frame parser
// Hunts for start code 0x2f, checks 8-byte frames and emits parameter
// records or warning count replies.
// ----------------------------------------------------------------------------
// Output path: once the checksum byte request is accepted, the result passes
// the input register, then the output register, before out_tvalid rises.
// Throughput: one request per cycle unless out_tready stalls the output.
// Reset: synchronous active-low rst_n clears the pipeline valids, returns the
// parser to hunting and loads command codes 1 (write) and 2 (read).
module uart_command_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_byte[7:0], warning_count[23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // slope_word[15:0], offset_word[31:16],
                                  // record_checksum[39:32], reply_word[55:40]
  output logic        out_tuser,  // event_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ucfp_pkg::*;

  cfg_t    cfg;
  req_t    req;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    res_ready;

  assign req.rx_byte       = in_tdata[7:0];
  assign req.warning_count = in_tdata[23:8];

  ucfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ucfp_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ucfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.reply_word, out_res.record_checksum,
                      out_res.offset_word, out_res.slope_word};
  assign out_tuser = out_res.event_kind;

endmodule
